// ----- src/isoep_pkg.sv -----
package isoep_pkg;

   // Default depth of the queue between scanner and arithmetic unit.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Fixed date/time characters: YYYY-MM-DDTHH:MM:SS
   localparam int MIN_LENGTH   = 19;
   localparam int FIXED_DIGITS = 14;

   // One fully scanned string, handed from the scanner to the arithmetic unit.
   typedef struct packed {
      logic                           too_short;
      logic [FIXED_DIGITS-1:0][7:0]   digits;        // raw bytes, year first
      logic [19:0]                    frac_acc;      // kept fraction digits
      logic [2:0]                     frac_count;    // number of kept digits
      logic                           offset_apply;
      logic                           offset_sign;   // 1 = '-'
      logic [3:0][7:0]                offset_digits; // H, H, M, M (last may be 0)
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- src/isoep_front.sv -----
module isoep_front import isoep_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_text_byte,
   input  logic             req_is_last,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   localparam logic [7:0] DOT_CHAR   = 8'd46;
   localparam logic [7:0] ZULU_CHAR  = 8'd90;
   localparam logic [7:0] PLUS_CHAR  = 8'd43;
   localparam logic [7:0] MINUS_CHAR = 8'd45;
   localparam logic [7:0] ZERO_CHAR  = 8'd48;
   localparam logic [7:0] NINE_CHAR  = 8'd57;
   localparam logic [2:0] FRAC_MAX   = 3'd6;
   localparam logic [2:0] OFF_BYTES  = 3'd5;

   typedef enum logic [2:0] {
      PH_FIXED,
      PH_FRACTION,
      PH_ZONE,
      PH_OFFSET,
      PH_DONE
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [4:0]                   pos_ff, pos_in;
   logic [FIXED_DIGITS-1:0][7:0] digits_ff, digits_in;
   logic [19:0]                  frac_ff, frac_in;
   logic [2:0]                   fcnt_ff, fcnt_in;
   logic                         sign_ff, sign_in;
   logic [3:0][7:0]              ob_ff, ob_in;
   logic [2:0]                   ocnt_ff, ocnt_in;

   logic                         slot_valid;
   logic [3:0]                   slot;
   phase_type                    zone_phase;
   logic                         zone_is_sign;
   logic                         is_digit;
   logic                         accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign is_digit  = (req_text_byte >= ZERO_CHAR) && (req_text_byte <= NINE_CHAR);

   // Position to digit slot; separators have no slot.
   always_comb begin
      slot_valid = 1'b1;
      slot       = 4'd0;
      unique case (pos_ff)
         5'd0, 5'd1, 5'd2, 5'd3: slot = pos_ff[3:0];
         5'd5:    slot = 4'd4;
         5'd6:    slot = 4'd5;
         5'd8:    slot = 4'd6;
         5'd9:    slot = 4'd7;
         5'd11:   slot = 4'd8;
         5'd12:   slot = 4'd9;
         5'd14:   slot = 4'd10;
         5'd15:   slot = 4'd11;
         5'd17:   slot = 4'd12;
         5'd18:   slot = 4'd13;
         default: slot_valid = 1'b0;
      endcase
   end

   // Zone scan step for the current byte.
   always_comb begin
      zone_is_sign = (req_text_byte == PLUS_CHAR) || (req_text_byte == MINUS_CHAR);
      priority if (req_text_byte == ZULU_CHAR) zone_phase = PH_DONE;
      else if (zone_is_sign)                   zone_phase = PH_OFFSET;
      else                                     zone_phase = PH_ZONE;
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      digits_in = digits_ff;
      frac_in   = frac_ff;
      fcnt_in   = fcnt_ff;
      sign_in   = sign_ff;
      ob_in     = ob_ff;
      ocnt_in   = ocnt_ff;
      push      = 1'b0;
      push_job  = '0;

      if (accept) begin
         unique case (phase_ff)
            PH_FIXED: begin
               if (pos_ff < 5'(MIN_LENGTH)) begin
                  if (slot_valid) digits_in[slot] = req_text_byte;
               end else if (req_text_byte == DOT_CHAR) begin
                  phase_in = PH_FRACTION;
               end else begin
                  phase_in = zone_phase;
                  if (zone_is_sign) begin
                     sign_in = (req_text_byte == MINUS_CHAR);
                     ocnt_in = 3'd0;
                  end
               end
            end
            PH_FRACTION: begin
               if (is_digit) begin
                  if (fcnt_ff < FRAC_MAX) begin
                     frac_in = frac_ff * 20'd10 + {16'd0, req_text_byte[3:0]};
                     fcnt_in = fcnt_ff + 3'd1;
                  end
               end else begin
                  phase_in = zone_phase;
                  if (zone_is_sign) begin
                     sign_in = (req_text_byte == MINUS_CHAR);
                     ocnt_in = 3'd0;
                  end
               end
            end
            PH_ZONE: begin
               phase_in = zone_phase;
               if (zone_is_sign) begin
                  sign_in = (req_text_byte == MINUS_CHAR);
                  ocnt_in = 3'd0;
               end
            end
            PH_OFFSET: begin
               // byte after HH (the colon) is not kept
               if (ocnt_ff < OFF_BYTES) begin
                  unique case (ocnt_ff)
                     3'd0:    ob_in[0] = req_text_byte;
                     3'd1:    ob_in[1] = req_text_byte;
                     3'd3:    ob_in[2] = req_text_byte;
                     3'd4:    ob_in[3] = req_text_byte;
                     default: ;
                  endcase
                  ocnt_in = ocnt_ff + 3'd1;
               end
            end
            PH_DONE: ;
            default: ;
         endcase

         if (pos_ff != 5'd31) pos_in = pos_ff + 5'd1;

         if (req_is_last) begin
            push                   = 1'b1;
            push_job.too_short     = (pos_ff < 5'(MIN_LENGTH - 1));
            push_job.digits        = digits_in;
            push_job.frac_acc      = frac_in;
            push_job.frac_count    = fcnt_in;
            push_job.offset_apply  = (phase_in == PH_OFFSET) && (ocnt_in >= 3'd4);
            push_job.offset_sign   = sign_in;
            push_job.offset_digits = ob_in;
            if (ocnt_in < OFF_BYTES) push_job.offset_digits[3] = 8'd0;

            phase_in  = PH_FIXED;
            pos_in    = '0;
            digits_in = '0;
            frac_in   = '0;
            fcnt_in   = '0;
            sign_in   = 1'b0;
            ob_in     = '0;
            ocnt_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIXED;
         pos_ff    <= '0;
         digits_ff <= '0;
         frac_ff   <= '0;
         fcnt_ff   <= '0;
         sign_ff   <= 1'b0;
         ob_ff     <= '0;
         ocnt_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         digits_ff <= digits_in;
         frac_ff   <= frac_in;
         fcnt_ff   <= fcnt_in;
         sign_ff   <= sign_in;
         ob_ff     <= ob_in;
         ocnt_ff   <= ocnt_in;
      end
   end

endmodule

// ----- src/isoep_queue.sv -----
module isoep_queue import isoep_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type              mem [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = mem[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/isoep_back.sv -----
module isoep_back import isoep_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  queue_status_type    q_status,
   input  job_type             head_job,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [63:0]  rsp_epoch_micros,
   output logic                rsp_too_short
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIELDS,
      S_MONQ,
      S_MONC,
      S_YEAR,
      S_ERAQ,
      S_ERAC,
      S_DAYS,
      S_SECS,
      S_MUL,
      S_SUM1,
      S_SUM2,
      S_OUT
   } state_type;

   function automatic logic signed [9:0] dig(input logic [7:0] b);
      return $signed({2'b00, b}) - 10'sd48;
   endfunction

   function automatic logic signed [12:0] pair(input logic [7:0] hi, input logic [7:0] lo);
      return 13'(dig(hi)) * 13'sd10 + 13'(dig(lo));
   endfunction

   // Zero padding of the fraction to six digits.
   function automatic logic [19:0] pad_scale(input logic [2:0] n);
      unique case (n)
         3'd0:    return 20'd1000000;
         3'd1:    return 20'd100000;
         3'd2:    return 20'd10000;
         3'd3:    return 20'd1000;
         3'd4:    return 20'd100;
         3'd5:    return 20'd10;
         default: return 20'd1;
      endcase
   endfunction

   // Days from March 1 to the first of the month; month index 0 = January.
   function automatic logic [8:0] month_start(input logic [3:0] m);
      unique case (m)
         4'd0:    return 9'd306;
         4'd1:    return 9'd337;
         4'd2:    return 9'd0;
         4'd3:    return 9'd31;
         4'd4:    return 9'd61;
         4'd5:    return 9'd92;
         4'd6:    return 9'd122;
         4'd7:    return 9'd153;
         4'd8:    return 9'd184;
         4'd9:    return 9'd214;
         4'd10:   return 9'd245;
         4'd11:   return 9'd275;
         default: return 9'd0;
      endcase
   endfunction

   function automatic logic [1:0] centuries(input logic [8:0] yoe);
      priority if (yoe >= 9'd300) return 2'd3;
      else if (yoe >= 9'd200)     return 2'd2;
      else if (yoe >= 9'd100)     return 2'd1;
      else                        return 2'd0;
   endfunction

   state_type            state_ff;
   job_type              job_ff;

   logic signed [19:0]   year_raw_ff, year_raw_in;
   logic [11:0]          mon_x_ff, mon_x_in;
   logic signed [12:0]   mday_m1_ff, mday_m1_in;
   logic signed [12:0]   hour_ff, hour_in;
   logic signed [12:0]   minute_ff, minute_in;
   logic signed [12:0]   sec_ff, sec_in;
   logic signed [18:0]   off_min_ff, off_min_in;
   logic [19:0]          frac_pad_ff, frac_pad_in;
   logic [23:0]          mprod_ff, mprod_in;
   logic [8:0]           mq_ff, mq_in;
   logic [3:0]           mon_ff, mon_in;
   logic [18:0]          y_x_ff, y_x_in;
   logic [37:0]          eprod_ff, eprod_in;
   logic signed [10:0]   era_ff, era_in;
   logic [8:0]           yoe_ff, yoe_in;
   logic signed [31:0]   days_ff, days_in;
   logic signed [47:0]   secs_ff, secs_in;
   logic [43:0]          plo_ff, plo_in;
   logic signed [43:0]   phi_ff, phi_in;
   logic signed [44:0]   shift_ff, shift_in;
   logic [63:0]          base_ff, base_in;
   logic [63:0]          total_in;

   logic                 rsp_valid_ff;
   logic signed [63:0]   rsp_epoch_ff;
   logic                 rsp_short_ff;

   logic [8:0]           mq_raw;
   logic [13:0]          mq12, mon_x14, mr;
   logic [9:0]           eq_raw, eq_fix;
   logic [18:0]          eq400, er;

   assign pop              = (state_ff == S_IDLE) && !q_status.empty;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_epoch_micros = rsp_epoch_ff;
   assign rsp_too_short    = rsp_short_ff;

   always_comb begin
      // field extraction; the year is taken in full from its four digits
      year_raw_in = 20'(dig(job_ff.digits[0])) * 20'sd1000
                  + 20'(dig(job_ff.digits[1])) * 20'sd100
                  + 20'(dig(job_ff.digits[2])) * 20'sd10
                  + 20'(dig(job_ff.digits[3]));
      // month - 1, biased by 45 years so floor division sees a positive value
      mon_x_in    = 12'(pair(job_ff.digits[4], job_ff.digits[5]) + 13'sd539);
      mday_m1_in  = pair(job_ff.digits[6], job_ff.digits[7]) - 13'sd1;
      hour_in     = pair(job_ff.digits[8], job_ff.digits[9]);
      minute_in   = pair(job_ff.digits[10], job_ff.digits[11]);
      sec_in      = pair(job_ff.digits[12], job_ff.digits[13]);
      off_min_in  = 19'(pair(job_ff.offset_digits[0], job_ff.offset_digits[1])) * 19'sd60
                  + 19'(pair(job_ff.offset_digits[2], job_ff.offset_digits[3]));
      frac_pad_in = 20'(40'(job_ff.frac_acc) * 40'(pad_scale(job_ff.frac_count)));

      // floor(x / 12) by reciprocal, estimate never low
      mprod_in = 24'(mon_x_ff) * 24'd2731;
      mq_raw   = mprod_ff[23:15];
      mq12     = 14'(mq_raw) * 14'd12;
      mon_x14  = {2'b00, mon_x_ff};
      if (mq12 > mon_x14) begin
         mq_in = mq_raw - 9'd1;
         mr    = mon_x14 + 14'd12 - mq12;
      end else begin
         mq_in = mq_raw;
         mr    = mon_x14 - mq12;
      end
      mon_in = mr[3:0];

      // March-based year, biased by 200 eras
      y_x_in = 19'(21'(year_raw_ff) + 21'({12'd0, mq_ff}) - 21'd45
                   - 21'(mon_ff < 4'd2) + 21'd80000);

      // floor(y / 400) by reciprocal, estimate never low
      eprod_in = 38'(y_x_ff) * 38'd335545;
      eq_raw   = eprod_ff[36:27];
      eq400    = 19'(eq_raw) * 19'd400;
      if (eq400 > y_x_ff) begin
         eq_fix = eq_raw - 10'd1;
         er     = y_x_ff + 19'd400 - eq400;
      end else begin
         eq_fix = eq_raw;
         er     = y_x_ff - eq400;
      end
      era_in = $signed({1'b0, eq_fix}) - 11'sd200;
      yoe_in = er[8:0];

      days_in = 32'(era_ff) * 32'sd146097
              + $signed({23'd0, yoe_ff}) * 32'sd365
              + $signed({25'd0, yoe_ff[8:2]})
              - $signed({30'd0, centuries(yoe_ff)})
              + $signed({23'd0, month_start(mon_ff)})
              + 32'(mday_m1_ff)
              - 32'sd719468;

      secs_in = 48'(days_ff) * 48'sd86400
              + 48'(hour_ff) * 48'sd3600
              + 48'(minute_ff) * 48'sd60
              + 48'(sec_ff);

      // seconds to microseconds in two halves
      plo_in   = 44'(secs_ff[23:0]) * 44'd1000000;
      phi_in   = 44'($signed(secs_ff[47:24])) * 44'sd1000000;
      shift_in = 45'(off_min_ff) * 45'sd60000000;

      base_in  = {phi_ff[39:0], 24'd0} + 64'(plo_ff);

      total_in = base_ff + 64'(frac_pad_ff);
      if (job_ff.offset_apply) begin
         if (job_ff.offset_sign) total_in = total_in + 64'(shift_ff);
         else                    total_in = total_in - 64'(shift_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (!q_status.empty) begin
                  job_ff <= head_job;
                  if (head_job.too_short) begin
                     rsp_epoch_ff <= '0;
                     rsp_short_ff <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_OUT;
                  end else begin
                     state_ff <= S_FIELDS;
                  end
               end
            end
            S_FIELDS: begin
               year_raw_ff <= year_raw_in;
               mon_x_ff    <= mon_x_in;
               mday_m1_ff  <= mday_m1_in;
               hour_ff     <= hour_in;
               minute_ff   <= minute_in;
               sec_ff      <= sec_in;
               off_min_ff  <= off_min_in;
               frac_pad_ff <= frac_pad_in;
               state_ff    <= S_MONQ;
            end
            S_MONQ: begin
               mprod_ff <= mprod_in;
               state_ff <= S_MONC;
            end
            S_MONC: begin
               mq_ff    <= mq_in;
               mon_ff   <= mon_in;
               state_ff <= S_YEAR;
            end
            S_YEAR: begin
               y_x_ff   <= y_x_in;
               state_ff <= S_ERAQ;
            end
            S_ERAQ: begin
               eprod_ff <= eprod_in;
               state_ff <= S_ERAC;
            end
            S_ERAC: begin
               era_ff   <= era_in;
               yoe_ff   <= yoe_in;
               state_ff <= S_DAYS;
            end
            S_DAYS: begin
               days_ff  <= days_in;
               state_ff <= S_SECS;
            end
            S_SECS: begin
               secs_ff  <= secs_in;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               plo_ff   <= plo_in;
               phi_ff   <= phi_in;
               shift_ff <= shift_in;
               state_ff <= S_SUM1;
            end
            S_SUM1: begin
               base_ff  <= base_in;
               state_ff <= S_SUM2;
            end
            S_SUM2: begin
               rsp_epoch_ff <= $signed(total_in);
               rsp_short_ff <= 1'b0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- src/iso8601_timestamp_to_epoch_us_top.sv -----
// Channel   Direction  Ports                                   Item
// req       in         req_valid/req_stall, text_byte, is_last one string character
// rsp       out        rsp_valid/rsp_stall, epoch_micros,      one converted timestamp
//                      too_short
//
// The scanner takes one character per cycle, without gaps, as long as the job
// queue has room; a string's result is computed by the arithmetic sequencer,
// which takes one job at a time, and a string shorter than 19 characters skips
// the arithmetic. Reset is synchronous and active high and clears scanner,
// queue and sequencer. req_stall rises only while the queue is full;
// rsp_stall holds the result register and the sequencer behind it.
module iso8601_timestamp_to_epoch_us_top import isoep_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_text_byte,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_epoch_micros,
   output logic               rsp_too_short
);

   queue_status_type q_status;
   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head_job;

   // Front: walks the string, stores the fixed-position digits, fraction and
   // zone offset, and emits one job per string on its last character.
   isoep_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_is_last   (req_is_last),
      .q_status      (q_status),
      .push          (push),
      .push_job      (push_job)
   );

   // Short job queue so the scanner keeps running while a result waits.
   isoep_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // Back: civil date to day count, then seconds, microseconds, fraction and offset.
   isoep_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_epoch_micros (rsp_epoch_micros),
      .rsp_too_short    (rsp_too_short)
   );

endmodule
